// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Property that is checked during reset as well.
`define ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset implication failed");

`endif

// ===== design/mtq_pkg.sv =====
// Package of the matrix to quaternion converter: widths, item types and
// the buses that travel along the square root and divider cell rows.
package mtq_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 14;

  // Root argument is below 2^(SAMPLE_WIDTH+1), roots fit in ROOT_W bits.
  localparam int A_W    = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = SAMPLE_WIDTH + 2;
  localparam int ROOT_W = SAMPLE_WIDTH;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int NUM_W  = SAMPLE_WIDTH + 1;
  localparam int MAG_W  = SAMPLE_WIDTH + 1;
  localparam int DIVN_W = MAG_W + FRAC_BITS;
  localparam int Q_W    = SAMPLE_WIDTH - 1;
  localparam int LANES  = 4;

  // Output component that carries the half root.
  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] m00;
    logic signed [SAMPLE_WIDTH-1:0] m01;
    logic signed [SAMPLE_WIDTH-1:0] m02;
    logic signed [SAMPLE_WIDTH-1:0] m10;
    logic signed [SAMPLE_WIDTH-1:0] m11;
    logic signed [SAMPLE_WIDTH-1:0] m12;
    logic signed [SAMPLE_WIDTH-1:0] m20;
    logic signed [SAMPLE_WIDTH-1:0] m21;
    logic signed [SAMPLE_WIDTH-1:0] m22;
  } mtq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] quat_w;
    logic signed [SAMPLE_WIDTH-1:0] quat_x;
    logic signed [SAMPLE_WIDTH-1:0] quat_y;
    logic signed [SAMPLE_WIDTH-1:0] quat_z;
    logic                           root_clamped;
  } mtq_out_t;

  // Bus along the square root row: two roots are built side by side.
  typedef struct packed {
    logic                         valid;
    logic [RAD_W-1:0]             rad_h;
    logic [RAD_W-1:0]             rad_s;
    logic [REM_W-1:0]             rem_h;
    logic [REM_W-1:0]             rem_s;
    logic [ROOT_W-1:0]            root_h;
    logic [ROOT_W-1:0]            root_s;
    logic [LANES-1:0][NUM_W-1:0]  num;
    slot_t                        slot;
    logic                         clamped;
  } sq_bus_t;

  // Bus along the divider row: one quotient bit per lane in each cell.
  typedef struct packed {
    logic                         valid;
    logic [LANES-1:0][DIVN_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]    quo;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0]             ovf;
    logic [DIVN_W-1:0]            dsh;
    logic                         zero;
    logic [ROOT_W-1:0]            half;
    slot_t                        slot;
    logic                         clamped;
  } dv_bus_t;

endpackage

// ===== design/matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Depends on mtq_pkg, mtq_sqrt_cell and mtq_div_cell.
//
//   channel  direction  payload    handshake
//   in       input      mtq_in_t   in_valid / in_stall
//   out      output     mtq_out_t  out_valid / out_stall
//
// One item is taken every cycle while in_stall is low. Items pass the setup
// register, square root row (a root bit per cell), rounding and divider setup
// registers, divider row (a quotient bit per cell) and output register. The
// whole pipeline advances together; it holds only while a result waits in the
// output register and out_stall is high. Reset clears the valid bits.
module matrix_to_quaternion import mtq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mtq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mtq_out_t out_data
);

  typedef struct packed {
    logic                        valid;
    logic [ROOT_W-1:0]           s_root;
    logic [ROOT_W-1:0]           h_root;
    logic [LANES-1:0][NUM_W-1:0] num;
    slot_t                       slot;
    logic                        clamped;
  } rnd_t;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< FRAC_BITS;

  logic                  en;
  sq_bus_t               s0_r;
  sq_bus_t               s0_nxt;
  sq_bus_t               sq_bus [ROOT_W+1];
  rnd_t                  rd_r;
  rnd_t                  rd_nxt;
  dv_bus_t               pp_r;
  dv_bus_t               pp_nxt;
  dv_bus_t               dv_bus [Q_W+1];
  logic                  out_valid_r;
  mtq_out_t              out_data_r;
  logic [LANES-1:0][SAMPLE_WIDTH-1:0] comp;

  logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [SUM_W-1:0] trace;
  logic signed [SUM_W-1:0] a_s;
  logic [1:0]              sel;
  logic                    tpos;
  logic [A_W-1:0]          a_u;
  logic [ROOT_W:0]         s_sum;
  logic [ROOT_W:0]         h_sum;

  function automatic logic [NUM_W-1:0] nw(input logic signed [SUM_W-1:0] v);
    return v[NUM_W-1:0];
  endfunction

  // The pipeline moves unless a finished result is held back.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Setup: pick the branch, the root argument and the three numerators.
  always_comb begin
    e00 = SUM_W'(in_data.m00);
    e01 = SUM_W'(in_data.m01);
    e02 = SUM_W'(in_data.m02);
    e10 = SUM_W'(in_data.m10);
    e11 = SUM_W'(in_data.m11);
    e12 = SUM_W'(in_data.m12);
    e20 = SUM_W'(in_data.m20);
    e21 = SUM_W'(in_data.m21);
    e22 = SUM_W'(in_data.m22);
    trace = e00 + e11 + e22;
    tpos  = trace > 0;
    sel   = 2'd0;
    if (e11 > e00) sel = 2'd1;
    if (e22 > ((sel == 2'd1) ? e11 : e00)) sel = 2'd2;
    s0_nxt         = '0;
    s0_nxt.valid   = in_valid;
    if (tpos) begin
      a_s            = trace + ONE;
      s0_nxt.slot    = SLOT_W;
      s0_nxt.num[1]  = nw(e21 - e12);
      s0_nxt.num[2]  = nw(e02 - e20);
      s0_nxt.num[3]  = nw(e10 - e01);
    end else begin
      case (sel)
        2'd1: begin
          a_s           = e11 - (e22 + e00) + ONE;
          s0_nxt.slot   = SLOT_Y;
          s0_nxt.num[0] = nw(e02 - e20);
          s0_nxt.num[3] = nw(e21 + e12);
          s0_nxt.num[1] = nw(e01 + e10);
        end
        2'd2: begin
          a_s           = e22 - (e00 + e11) + ONE;
          s0_nxt.slot   = SLOT_Z;
          s0_nxt.num[0] = nw(e10 - e01);
          s0_nxt.num[1] = nw(e02 + e20);
          s0_nxt.num[2] = nw(e12 + e21);
        end
        default: begin
          a_s           = e00 - (e11 + e22) + ONE;
          s0_nxt.slot   = SLOT_X;
          s0_nxt.num[0] = nw(e21 - e12);
          s0_nxt.num[2] = nw(e10 + e01);
          s0_nxt.num[3] = nw(e20 + e02);
        end
      endcase
    end
    // A negative argument is clamped to zero and flagged.
    s0_nxt.clamped = a_s[SUM_W-1];
    a_u            = a_s[SUM_W-1] ? '0 : a_s[A_W-1:0];
    s0_nxt.rad_h   = {{(RAD_W-A_W-FRAC_BITS+2){1'b0}}, a_u, {(FRAC_BITS-2){1'b0}}};
    s0_nxt.rad_s   = {{(RAD_W-A_W-FRAC_BITS){1'b0}}, a_u, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // Square root row.
  assign sq_bus[0] = s0_r;
  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    mtq_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bus_i (sq_bus[g]),
      .bus_o (sq_bus[g+1])
    );
  end

  // Round both roots to nearest. The argument range keeps them below 2^16.
  always_comb begin
    s_sum = {1'b0, sq_bus[ROOT_W].root_s} +
            (ROOT_W+1)'(sq_bus[ROOT_W].rem_s > REM_W'(sq_bus[ROOT_W].root_s));
    h_sum = {1'b0, sq_bus[ROOT_W].root_h} +
            (ROOT_W+1)'(sq_bus[ROOT_W].rem_h > REM_W'(sq_bus[ROOT_W].root_h));
    rd_nxt.valid   = sq_bus[ROOT_W].valid;
    rd_nxt.s_root  = s_sum[ROOT_W-1:0];
    rd_nxt.h_root  = h_sum[ROOT_W-1:0];
    rd_nxt.num     = sq_bus[ROOT_W].num;
    rd_nxt.slot    = sq_bus[ROOT_W].slot;
    rd_nxt.clamped = sq_bus[ROOT_W].clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r.valid <= 1'b0;
    end else if (en) begin
      rd_r <= rd_nxt;
    end
  end

  // Divider setup: magnitude, rounding offset and quotient overflow check.
  always_comb begin
    logic [MAG_W-1:0]  mag;
    logic [DIVN_W-1:0] s_top;
    pp_nxt         = '0;
    pp_nxt.valid   = rd_r.valid;
    pp_nxt.half    = rd_r.h_root;
    pp_nxt.slot    = rd_r.slot;
    pp_nxt.clamped = rd_r.clamped;
    pp_nxt.zero    = rd_r.s_root == '0;
    pp_nxt.dsh     = DIVN_W'(rd_r.s_root) << (Q_W - 1);
    s_top          = DIVN_W'(rd_r.s_root) << Q_W;
    for (int l = 0; l < LANES; l++) begin
      pp_nxt.neg[l] = rd_r.num[l][NUM_W-1];
      mag           = pp_nxt.neg[l] ? (MAG_W'(0) - rd_r.num[l]) : rd_r.num[l];
      pp_nxt.rem[l] = (DIVN_W'(mag) << (FRAC_BITS - 1)) +
                      DIVN_W'(rd_r.s_root[ROOT_W-1:1]);
      pp_nxt.ovf[l] = pp_nxt.rem[l] >= s_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r.valid <= 1'b0;
    end else if (en) begin
      pp_r <= pp_nxt;
    end
  end

  // Divider row.
  assign dv_bus[0] = pp_r;
  for (genvar g = 0; g < Q_W; g++) begin : g_div
    mtq_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bus_i (dv_bus[g]),
      .bus_o (dv_bus[g+1])
    );
  end

  // Sign, saturation, zero root handling and placement of the half root.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dv_bus[Q_W].slot == slot_t'(l)) begin
        comp[l] = dv_bus[Q_W].half;
      end else if (dv_bus[Q_W].zero) begin
        comp[l] = '0;
      end else if (dv_bus[Q_W].ovf[l]) begin
        comp[l] = dv_bus[Q_W].neg[l] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
      end else if (dv_bus[Q_W].neg[l]) begin
        comp[l] = SAMPLE_WIDTH'(0) - {1'b0, dv_bus[Q_W].quo[l]};
      end else begin
        comp[l] = {1'b0, dv_bus[Q_W].quo[l]};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r             <= dv_bus[Q_W].valid;
      out_data_r.quat_w       <= comp[0];
      out_data_r.quat_x       <= comp[1];
      out_data_r.quat_y       <= comp[2];
      out_data_r.quat_z       <= comp[3];
      out_data_r.root_clamped <= dv_bus[Q_W].clamped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/mtq_sqrt_cell.sv =====
// One square root cell: a single digit step for both roots, registered.
// Depends on mtq_pkg.
module mtq_sqrt_cell import mtq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  sq_bus_t bus_i,
  output sq_bus_t bus_o
);

  sq_bus_t           bus_r;
  sq_bus_t           bus_nxt;
  logic [REM_W-1:0]  rem_h_t;
  logic [REM_W-1:0]  rem_s_t;
  logic [REM_W-1:0]  trial_h;
  logic [REM_W-1:0]  trial_s;

  // Bring down two radicand bits and try to subtract 4*root+1.
  always_comb begin
    bus_nxt = bus_i;
    rem_h_t = {bus_i.rem_h[REM_W-3:0], bus_i.rad_h[RAD_W-1:RAD_W-2]};
    rem_s_t = {bus_i.rem_s[REM_W-3:0], bus_i.rad_s[RAD_W-1:RAD_W-2]};
    trial_h = {{(REM_W-ROOT_W-2){1'b0}}, bus_i.root_h, 2'b01};
    trial_s = {{(REM_W-ROOT_W-2){1'b0}}, bus_i.root_s, 2'b01};
    bus_nxt.rad_h = {bus_i.rad_h[RAD_W-3:0], 2'b00};
    bus_nxt.rad_s = {bus_i.rad_s[RAD_W-3:0], 2'b00};
    if (rem_h_t >= trial_h) begin
      bus_nxt.rem_h  = rem_h_t - trial_h;
      bus_nxt.root_h = {bus_i.root_h[ROOT_W-2:0], 1'b1};
    end else begin
      bus_nxt.rem_h  = rem_h_t;
      bus_nxt.root_h = {bus_i.root_h[ROOT_W-2:0], 1'b0};
    end
    if (rem_s_t >= trial_s) begin
      bus_nxt.rem_s  = rem_s_t - trial_s;
      bus_nxt.root_s = {bus_i.root_s[ROOT_W-2:0], 1'b1};
    end else begin
      bus_nxt.rem_s  = rem_s_t;
      bus_nxt.root_s = {bus_i.root_s[ROOT_W-2:0], 1'b0};
    end
  end

  // Only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

// ===== design/mtq_div_cell.sv =====
// One divider cell: a single restoring quotient bit for every lane, registered.
// Depends on mtq_pkg.
module mtq_div_cell import mtq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  dv_bus_t bus_i,
  output dv_bus_t bus_o
);

  dv_bus_t bus_r;
  dv_bus_t bus_nxt;

  // Compare each partial remainder with the shifted divisor, then halve it.
  always_comb begin
    bus_nxt     = bus_i;
    bus_nxt.dsh = {1'b0, bus_i.dsh[DIVN_W-1:1]};
    for (int l = 0; l < LANES; l++) begin
      if (bus_i.rem[l] >= bus_i.dsh) begin
        bus_nxt.rem[l] = bus_i.rem[l] - bus_i.dsh;
        bus_nxt.quo[l] = {bus_i.quo[l][Q_W-2:0], 1'b1};
      end else begin
        bus_nxt.quo[l] = {bus_i.quo[l][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

// ===== design/mtq_checker.sv =====
// Port checker of the matrix to quaternion converter, bound to the top level.
// Depends on mtq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtq_checker import mtq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input mtq_out_t out_data
);

  // A clamped root leaves every component at zero.
  `ASSERT_SAME(a_clamp_zero, clk, rst_n, out_valid && out_data.root_clamped, out_data.quat_w == 0 && out_data.quat_x == 0 && out_data.quat_y == 0 && out_data.quat_z == 0)

  // The input side stalls only behind a held result.
  `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A stalled input item stays offered.
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)

  // A held result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // Nothing is offered right after reset.
  `ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind matrix_to_quaternion mtq_checker u_mtq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb_matrix_to_quaternion.sv =====
// Self-checking testbench of the matrix to quaternion converter.
// Depends on mtq_pkg and matrix_to_quaternion; compares every output item
// against a fixed-point predictor of the conversion.
`timescale 1ns / 100ps

module tb_matrix_to_quaternion;
  import mtq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mtq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  mtq_out_t out_data;

  mtq_out_t quat_expected[$];
  int       error_count;
  int       idle_enable;   // random gaps on both sides while set
  int       hold_cycles;   // receiver hold-off requested by a test

  matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    #(20 * 400000);
    $display("** matrix_to_quaternion: FAILED **");
    $finish;
  end

  // Rounded integer square root, nearest.
  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  // Scaled division rounding half away from zero.
  function automatic longint div_by_root(longint d, longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    if (s == 0) return 0;
    mag = (d < 0) ? longint'(-d) : d;
    mag = mag << (FRAC_BITS - 1);
    q = (mag + s / 2) / s;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] clip(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[SAMPLE_WIDTH-1:0];
    if (v < lo) return lo[SAMPLE_WIDTH-1:0];
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Predicts the quaternion of one matrix.
  function automatic mtq_out_t predict_quat(mtq_in_t mi);
    longint m[3][3];
    longint q[3];
    longint w, tr, a;
    longint unsigned s;
    int i, j, k;
    mtq_out_t r;
    m[0][0] = mi.m00; m[0][1] = mi.m01; m[0][2] = mi.m02;
    m[1][0] = mi.m10; m[1][1] = mi.m11; m[1][2] = mi.m12;
    m[2][0] = mi.m20; m[2][1] = mi.m21; m[2][2] = mi.m22;
    r.root_clamped = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      a = tr + (longint'(1) << FRAC_BITS);
      w = root_nearest(a << (FRAC_BITS - 2));
      s = root_nearest(a << FRAC_BITS);
      q[0] = div_by_root(m[2][1] - m[1][2], s);
      q[1] = div_by_root(m[0][2] - m[2][0], s);
      q[2] = div_by_root(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = m[i][i] - (m[j][j] + m[k][k]) + (longint'(1) << FRAC_BITS);
      if (a < 0) begin
        a = 0;
        r.root_clamped = 1'b1;
      end
      q[i] = root_nearest(a << (FRAC_BITS - 2));
      s = root_nearest(a << FRAC_BITS);
      w = div_by_root(m[k][j] - m[j][k], s);
      q[j] = div_by_root(m[j][i] + m[i][j], s);
      q[k] = div_by_root(m[k][i] + m[i][k], s);
    end
    r.quat_w = clip(w);
    r.quat_x = clip(q[0]);
    r.quat_y = clip(q[1]);
    r.quat_z = clip(q[2]);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Receiver: random stall bursts, or one long hold-off when requested.
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Checker: each accepted item is compared with the oldest prediction.
  always @(posedge clk) begin
    mtq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_expected.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = quat_expected.pop_front();
        if (out_data.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.root_clamped !== want.root_clamped)
          report_mismatch("root_clamped", out_data.root_clamped, want.root_clamped);
      end
    end
  end

  // Sends one matrix, with an optional gap in front, and records its prediction.
  task automatic send_matrix(mtq_in_t mi);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_expected.push_back(predict_quat(mi));
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
  endtask

  function automatic mtq_in_t diag_matrix(int d0, int d1, int d2);
    mtq_in_t mi;
    mi = '0;
    mi.m00 = SAMPLE_WIDTH'(d0);
    mi.m11 = SAMPLE_WIDTH'(d1);
    mi.m22 = SAMPLE_WIDTH'(d2);
    return mi;
  endfunction

  // Random entry in [-1, 1] of Q1.14.
  function automatic logic signed [SAMPLE_WIDTH-1:0] unit_entry;
    return SAMPLE_WIDTH'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_entry;
    logic signed [SAMPLE_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = unit_entry();
      default: v = SAMPLE_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Random matrix in the range of a rotation: Q1.14 entries bounded by one.
  function automatic mtq_in_t rotation_like;
    mtq_in_t mi;
    mi.m00 = unit_entry();
    mi.m01 = unit_entry();
    mi.m02 = unit_entry();
    mi.m10 = unit_entry();
    mi.m11 = unit_entry();
    mi.m12 = unit_entry();
    mi.m20 = unit_entry();
    mi.m21 = unit_entry();
    mi.m22 = unit_entry();
    return mi;
  endfunction

  // Identity, each axis branch, ties and extremes.
  task automatic test_directed;
    mtq_in_t mi;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(-5000, -5000, -5000));
    send_matrix(diag_matrix(-100, -100, -300));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(-16384, 0, 16384));
    mi = diag_matrix(0, 0, -16384);
    mi.m01 = 16'sh7fff; mi.m10 = 16'sh7fff;
    send_matrix(mi);
    mi = diag_matrix(-30000, -32768, 32767);
    mi.m02 = 16'sh8000; mi.m20 = 16'sh8000; mi.m12 = 16'sh7fff; mi.m21 = 16'sh8000;
    send_matrix(mi);
    mi = diag_matrix(1, 0, 0);
    mi.m21 = 16'sh7fff; mi.m12 = 16'sh8000; mi.m02 = 16'sh7fff; mi.m20 = 16'sh8000;
    send_matrix(mi);
    mi = diag_matrix(-16384, -16384, -16384);
    mi.m12 = 16'sh7fff; mi.m21 = 16'sh7fff;
    send_matrix(mi);
    send_matrix('1);
    send_matrix({9{16'sh7fff}});
    send_matrix({9{16'sh8000}});
    end_burst();
  endtask

  // Random matrices: mostly rotation-like, the rest arbitrary and extreme.
  task automatic test_random(int count);
    mtq_in_t mi;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        mi = rotation_like();
      end else begin
        mi.m00 = rnd_entry(); mi.m01 = rnd_entry(); mi.m02 = rnd_entry();
        mi.m10 = rnd_entry(); mi.m11 = rnd_entry(); mi.m12 = rnd_entry();
        mi.m20 = rnd_entry(); mi.m21 = rnd_entry(); mi.m22 = rnd_entry();
      end
      send_matrix(mi);
    end
    end_burst();
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure;
    hold_cycles = 120;
    test_random(100);
  endtask

  // Full-rate stream with no gaps on either side.
  task automatic test_streaming;
    idle_enable = 0;
    test_random(400);
  endtask

  initial begin
    int wait_cycles;
    error_count = 0;
    idle_enable = 1;
    hold_cycles = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1100);
    test_backpressure();
    test_streaming();
    // Drain the pipeline.
    wait_cycles = 0;
    while (quat_expected.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && quat_expected.size() == 0) begin
      $display("** matrix_to_quaternion: PASSED **");
    end else begin
      $display("** matrix_to_quaternion: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mtq_pkg.sv
design/mtq_sqrt_cell.sv
design/mtq_div_cell.sv
design/matrix_to_quaternion.sv
design/mtq_checker.sv
verif/tb_matrix_to_quaternion.sv
